>>> rtl/pscl_pkg.sv
// Package for the press sequence code lock: state types, register map,
// reset values, result word layout and state-to-code helpers.
// No dependencies.
package pscl_pkg;

  // Configuration register map (word index = paddr[3:2])
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] RegStepTimeout   = 2'd0;
  localparam logic [1:0] RegOpenTime      = 2'd1;
  localparam logic [1:0] RegErrorTime     = 2'd2;
  localparam logic [1:0] RegLongPressScan = 2'd3;

  localparam logic [15:0] StepTimeoutRst  = 16'd5000;
  localparam logic [15:0] OpenTimeRst     = 16'd3000;
  localparam logic [15:0] ErrorTimeRst    = 16'd2000;
  localparam logic [15:0] LongPressRst    = 16'd250;

  // Lock states, one-hot
  typedef enum logic [6:0] {
    LK_IDLE  = 7'b000_0001,
    LK_OK1   = 7'b000_0010,
    LK_OK2   = 7'b000_0100,
    LK_OPEN  = 7'b000_1000,
    LK_ERR1  = 7'b001_0000,
    LK_ERR2  = 7'b010_0000,
    LK_ERROR = 7'b100_0000
  } lock_state_e;

  // Press classifier states, one-hot
  typedef enum logic [2:0] {
    PR_NONE  = 3'b001,
    PR_SHORT = 3'b010,
    PR_LONG  = 3'b100
  } press_state_e;

  // Encoded modes as seen on the result word
  localparam logic [2:0] LockCodeIdle  = 3'd0;
  localparam logic [2:0] LockCodeOk1   = 3'd1;
  localparam logic [2:0] LockCodeOk2   = 3'd2;
  localparam logic [2:0] LockCodeOpen  = 3'd3;
  localparam logic [2:0] LockCodeErr1  = 3'd4;
  localparam logic [2:0] LockCodeErr2  = 3'd5;
  localparam logic [2:0] LockCodeError = 3'd6;

  localparam logic [1:0] PressCodeNone  = 2'd0;
  localparam logic [1:0] PressCodeShort = 2'd1;
  localparam logic [1:0] PressCodeLong  = 2'd2;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [5:0] pad;
    logic       press_changed;
    logic       lock_changed;
    logic [1:0] press_mode;
    logic [2:0] lock_mode;
    logic       open_led;
    logic       error_led;
    logic       ready_led;
  } out_word_t;

  function automatic logic [2:0] lock_code(lock_state_e s);
    logic [2:0] c;
    c = LockCodeError;
    unique case (s)
      LK_IDLE:  c = LockCodeIdle;
      LK_OK1:   c = LockCodeOk1;
      LK_OK2:   c = LockCodeOk2;
      LK_OPEN:  c = LockCodeOpen;
      LK_ERR1:  c = LockCodeErr1;
      LK_ERR2:  c = LockCodeErr2;
      LK_ERROR: c = LockCodeError;
      default:  c = LockCodeError;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] press_code(press_state_e s);
    logic [1:0] c;
    c = PressCodeNone;
    unique case (s)
      PR_NONE:  c = PressCodeNone;
      PR_SHORT: c = PressCodeShort;
      PR_LONG:  c = PressCodeLong;
      default:  c = PressCodeNone;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/press_sequence_code_lock.sv
// One-button code lock: press classifier, seven-state lock, APB config
// registers and a two-deep output buffer. Depends on pscl_pkg.
//
// Channel  | dir | payload                                     | handshake
// ---------+-----+---------------------------------------------+--------------------
// s_axis   | in  | tdata[0] button_pressed, tuser[0] scan_tick | tvalid/tready
// m_axis   | out | tdata[9:0] result word (see port comments)  | tvalid/tready
// apb      | in  | 4 x 16-bit regs at 0x0,0x4,0x8,0xC          | psel/penable, pready=1
//
// One word per clock while s_axis_tready is high: lock and classifier next-state
// logic sits between the state registers and the output register.
// Reset (rst_ni low, async) puts the lock in idle, the classifier in not
// pressed, clears events and counters and loads the default timings.
// Output stall: a skid register holds one more result; s_axis_tready drops
// only while both output and skid registers are full.
module press_sequence_code_lock
  import pscl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [0] button_pressed, [7:1] zero
  input  logic [0:0]          s_axis_tuser,  // [0] scan_tick
  // stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // [0] ready_led, [1] error_led,
                                             // [2] open_led, [5:3] lock_mode,
                                             // [7:6] press_mode, [8] lock_changed,
                                             // [9] press_changed, [15:10] zero
  // config
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // ---------------- configuration registers ----------------
  logic [15:0] step_timeout_q, open_time_q, error_time_q, long_press_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_timeout_q <= StepTimeoutRst;
      open_time_q    <= OpenTimeRst;
      error_time_q   <= ErrorTimeRst;
      long_press_q   <= LongPressRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegStepTimeout:   step_timeout_q <= pwdata[15:0];
        RegOpenTime:      open_time_q    <= pwdata[15:0];
        RegErrorTime:     error_time_q   <= pwdata[15:0];
        RegLongPressScan: long_press_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegStepTimeout:   prdata = {16'd0, step_timeout_q};
      RegOpenTime:      prdata = {16'd0, open_time_q};
      RegErrorTime:     prdata = {16'd0, error_time_q};
      RegLongPressScan: prdata = {16'd0, long_press_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------- state ----------------
  lock_state_e  lock_q, lock_d;
  press_state_e press_q, press_d;
  logic [15:0]  cnt_q, cnt_d;     // lock countdown
  logic [15:0]  hold_q, hold_d;   // scans held
  logic         short_q, short_d, long_q, long_d;

  logic         pressed, scan, in_acc;
  logic         short_ev, long_ev;  // pending after this tick's scan
  logic [15:0]  hold_inc;
  out_word_t    res;

  assign pressed  = s_axis_tdata[0];
  assign scan     = s_axis_tuser[0];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign hold_inc = hold_q + 16'd1;

  // press classifier, only on a scan tick
  always_comb begin
    press_d  = press_q;
    hold_d   = hold_q;
    short_ev = short_q;
    long_ev  = long_q;
    if (scan) begin
      unique case (press_q)
        PR_NONE: begin
          if (pressed) begin
            press_d = PR_SHORT;
            hold_d  = 16'd0;
          end
        end
        PR_SHORT: begin
          hold_d = hold_inc;
          if (hold_inc >= long_press_q) press_d = PR_LONG;
          // release wins over the threshold on the same scan
          if (!pressed) begin
            press_d  = PR_NONE;
            short_ev = 1'b1;
          end
        end
        PR_LONG: begin
          if (!pressed) begin
            press_d = PR_NONE;
            long_ev = 1'b1;
          end
        end
        default: press_d = PR_NONE;
      endcase
    end
  end

  // lock; a consumed event overrides the timeout and reloads the countdown
  always_comb begin
    lock_d  = lock_q;
    cnt_d   = cnt_q;
    short_d = short_ev;
    long_d  = long_ev;
    if (lock_q != LK_IDLE) begin
      if (cnt_q != 16'd0) cnt_d = cnt_q - 16'd1;
      else                lock_d = LK_IDLE;
    end
    unique case (lock_q)
      LK_IDLE: begin
        short_d = 1'b0;
        long_d  = 1'b0;
        // long after short: long wins
        if (long_ev) begin
          lock_d = LK_ERR1;
          cnt_d  = step_timeout_q;
        end else if (short_ev) begin
          lock_d = LK_OK1;
          cnt_d  = step_timeout_q;
        end
      end
      LK_OK1: begin
        short_d = 1'b0;
        long_d  = 1'b0;
        if (long_ev) begin
          lock_d = LK_OK2;
          cnt_d  = step_timeout_q;
        end else if (short_ev) begin
          lock_d = LK_ERR2;
          cnt_d  = step_timeout_q;
        end
      end
      LK_OK2: begin
        short_d = 1'b0;
        long_d  = 1'b0;
        if (long_ev) begin
          lock_d = LK_ERROR;
          cnt_d  = error_time_q;
        end else if (short_ev) begin
          lock_d = LK_OPEN;
          cnt_d  = open_time_q;
        end
      end
      LK_ERR1, LK_ERR2: begin
        // short consumed first; long stays pending if short was there
        if (short_ev) short_d = 1'b0;
        else          long_d  = 1'b0;
        if (short_ev || long_ev) begin
          if (lock_q == LK_ERR1) begin
            lock_d = LK_ERR2;
            cnt_d  = step_timeout_q;
          end else begin
            lock_d = LK_ERROR;
            cnt_d  = error_time_q;
          end
        end
      end
      LK_OPEN, LK_ERROR: ;
      default: begin
        lock_d = LK_ERROR;
        cnt_d  = cnt_q;
      end
    endcase
  end

  always_comb begin
    res               = '0;
    res.ready_led     = (lock_q == LK_IDLE);
    res.error_led     = (lock_q == LK_ERROR);
    res.open_led      = (lock_q == LK_OPEN);
    res.lock_mode     = lock_code(lock_d);
    res.press_mode    = press_code(press_d);
    res.lock_changed  = (lock_d != lock_q);
    res.press_changed = (press_d != press_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q  <= LK_IDLE;
      press_q <= PR_NONE;
      cnt_q   <= 16'd0;
      hold_q  <= 16'd0;
      short_q <= 1'b0;
      long_q  <= 1'b0;
    end else if (in_acc) begin
      lock_q  <= lock_d;
      press_q <= press_d;
      cnt_q   <= cnt_d;
      hold_q  <= hold_d;
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  // ---------------- output register + skid ----------------
  logic      out_vld_q, skid_vld_q, out_pop;
  out_word_t out_q, skid_q;

  assign out_pop       = out_vld_q & m_axis_tready;
  assign s_axis_tready = ~skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_pop) skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      if (out_vld_q && !out_pop) skid_vld_q <= 1'b1;
      else                       out_vld_q  <= 1'b1;
    end else if (out_pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_pop) out_q <= skid_q;
    end else if (in_acc) begin
      if (out_vld_q && !out_pop) skid_q <= res;
      else                       out_q  <= res;
    end
  end

endmodule
